FILE: rtl/bounded_deque_with_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque block.
// All checks are clocked on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, codes and ring helpers for the bounded deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  // Ring size and derived widths
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = IDX_W + 1;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);
  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);

  // Request action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Control states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Ring position of offset off from base, wrapped at DEPTH (off < DEPTH)
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit words with a linear search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, in_action, in_value) carries one
//   request: push front, push back, pop front, pop back or search. Every
//   request yields exactly one result on the output channel (out_valid /
//   out_stall, out_status, out_found).
//   Pushes, pops and unused codes complete in the accepting cycle; the
//   result appears in the output register in the cycle after acceptance.
//   A search reads the live entries from the entry memory through its
//   registered read port, one read per cycle, front to back, and stops at
//   the first hit; an empty queue answers at once, with no walk. The read
//   port register lies between each read and the compare of its word.
//   One request is in flight at a time; in_stall stays high during a search.
//   Reset (synchronous, rst_n low) empties the queue and drops any pending
//   result; stored words are not cleared, and no empty slot is ever read.
//   While out_stall holds a result, it stays in the output register and no
//   new request is accepted until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic [bdq_pkg::ACT_W-1:0]            in_action,
  input  wire logic signed [bdq_pkg::WORD_W-1:0]    in_value,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic [bdq_pkg::STAT_W-1:0]           out_status,
  output      logic                                 out_found
);

  // Entry memory and its registered read port
  bdq_pkg::word_t  mem [bdq_pkg::DEPTH];
  bdq_pkg::word_t  rd_data_r;

  // Control and queue state
  bdq_pkg::state_t state_r, state_nxt;
  bdq_pkg::idx_t   front_r, front_nxt;
  bdq_pkg::cnt_t   count_r, count_nxt;

  // Search walk
  bdq_pkg::cnt_t   rd_off_r, rd_off_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic            hit_r, hit_nxt;
  bdq_pkg::word_t  word_r, word_nxt;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  bdq_pkg::status_t out_status_r, out_status_nxt;
  logic            out_found_r, out_found_nxt;

  // Combinational helpers
  bdq_pkg::action_t act;
  logic            in_acc;
  logic            out_free;
  logic            found_now;
  logic            srch_done;
  logic            mem_re;
  logic            mem_we;
  bdq_pkg::idx_t   mem_waddr;
  bdq_pkg::idx_t   rd_addr;
  bdq_pkg::idx_t   front_dec;
  logic            res_load;
  bdq_pkg::status_t res_status;
  logic            res_found;

  assign act       = bdq_pkg::action_t'(in_action);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign found_now = hit_r || (cmp_vld_r && (rd_data_r == word_r));
  assign srch_done = found_now || ((rd_off_r == count_r) && !cmp_vld_r);
  assign rd_addr   = bdq_pkg::ring_add(front_r, rd_off_r);
  assign front_dec = (front_r == '0) ? bdq_pkg::IDX_LAST : front_r - 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (in_acc && (act == bdq_pkg::ACT_SEARCH) && (count_r != '0)) begin
          state_nxt = bdq_pkg::ST_SEARCH;
        end
      end
      bdq_pkg::ST_SEARCH: begin
        if (srch_done && out_free) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // State outputs: request stall and memory read issue
  always_comb begin
    in_stall = 1'b1;
    mem_re   = 1'b0;
    unique case (state_r)
      bdq_pkg::ST_IDLE: begin
        in_stall = !out_free;
      end
      bdq_pkg::ST_SEARCH: begin
        mem_re = !found_now && (rd_off_r < count_r);
      end
    endcase
  end

  // Queue update, search walk and result selection
  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    rd_off_nxt  = rd_off_r;
    cmp_vld_nxt = mem_re;
    hit_nxt     = hit_r;
    word_nxt    = word_r;
    mem_we      = 1'b0;
    mem_waddr   = front_dec;
    res_load    = 1'b0;
    res_status  = bdq_pkg::STAT_DONE;
    res_found   = 1'b0;

    if (in_acc) begin
      res_load = 1'b1;
      unique case (act)
        bdq_pkg::ACT_PUSH_FRONT: begin
          if (count_r == bdq_pkg::CNT_FULL) begin
            res_status = bdq_pkg::STAT_FULL;
          end else begin
            front_nxt = front_dec;
            mem_we    = 1'b1;
            mem_waddr = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::ACT_PUSH_BACK: begin
          if (count_r == bdq_pkg::CNT_FULL) begin
            res_status = bdq_pkg::STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = bdq_pkg::ring_add(front_r, count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        bdq_pkg::ACT_POP_FRONT: begin
          if (count_r == '0) begin
            res_status = bdq_pkg::STAT_EMPTY;
          end else begin
            front_nxt = bdq_pkg::ring_add(front_r, bdq_pkg::CNT_ONE);
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::ACT_POP_BACK: begin
          if (count_r == '0) begin
            res_status = bdq_pkg::STAT_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        bdq_pkg::ACT_SEARCH: begin
          // Empty queue answers at once; otherwise start the walk
          word_nxt    = in_value;
          rd_off_nxt  = '0;
          hit_nxt     = 1'b0;
          cmp_vld_nxt = 1'b0;
          res_load    = (count_r == '0);
        end
        default: begin
          // Unused action codes: report done, change nothing
        end
      endcase
    end else if (state_r == bdq_pkg::ST_SEARCH) begin
      // Advance the walk one entry a cycle and keep any hit
      if (mem_re) begin
        rd_off_nxt = rd_off_r + 1'b1;
      end
      if (found_now) begin
        hit_nxt = 1'b1;
      end
      res_load  = srch_done && out_free;
      res_found = found_now;
    end

    // Output register: load a result, else drop it once taken
    if (res_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_found_nxt  = res_found;
    end else begin
      out_valid_nxt  = out_valid_r && out_stall;
      out_status_nxt = out_status_r;
      out_found_nxt  = out_found_r;
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      rd_off_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hit_r       <= hit_nxt;
      rd_off_r    <= rd_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;

  // Checks
  `BDQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= bdq_pkg::CNT_FULL, "entry count beyond depth")
  `BDQ_ASSERT_IMPL(a_walk_bound, state_r == bdq_pkg::ST_SEARCH, rd_off_r <= count_r, "search walked past the back")
  `BDQ_ASSERT_NEXT(a_search_hold, state_r == bdq_pkg::ST_SEARCH, $stable(count_r) && $stable(front_r), "queue changed during search")
  `BDQ_ASSERT_IMPL(a_found_done, out_valid_r && out_found_r, out_status_r == bdq_pkg::STAT_DONE, "found flag with bad status")

endmodule

`default_nettype wire
